/* hw/rtl/assert_macros.svh */
// assertion macros used by the transmitter core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* hw/rtl/irft_pkg.sv */
// types and constants of the infrared frame transmitter
package irft_pkg;

  localparam int unsigned AddrW  = 13;
  localparam int unsigned CmdW   = 7;
  localparam int unsigned FrameW = 4;
  localparam int unsigned TickW  = 10;
  localparam int unsigned MarkW  = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 13;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEVICE_ADDRESS   = 3'd0,
    CFG_FRAME_COUNT      = 3'd1,
    CFG_FRAME_GAP_TICKS  = 3'd2,
    CFG_START_MARK_TICKS = 3'd3,
    CFG_ONE_MARK_TICKS   = 3'd4,
    CFG_ZERO_MARK_TICKS  = 3'd5,
    CFG_SPACE_TICKS      = 3'd6
  } cfg_idx_e;

  localparam logic [AddrW-1:0]  RstDeviceAddress = 13'h1E3A;
  localparam logic [FrameW-1:0] RstFrameCount    = 4'd3;
  localparam logic [TickW-1:0]  RstFrameGap      = 10'd430;
  localparam logic [MarkW-1:0]  RstStartMark     = 8'd96;
  localparam logic [MarkW-1:0]  RstOneMark       = 8'd48;
  localparam logic [MarkW-1:0]  RstZeroMark      = 8'd24;
  localparam logic [MarkW-1:0]  RstSpace         = 8'd24;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_SEND = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_START_MARK  = 3'd1,
    PH_START_SPACE = 3'd2,
    PH_BIT_MARK    = 3'd3,
    PH_BIT_SPACE   = 3'd4,
    PH_GAP         = 3'd5
  } phase_e;

  typedef struct packed {
    logic carrier_on;
    logic busy;
    logic done;
  } result_t;

endpackage

/* hw/rtl/ir_remote_frame_transmitter_core.sv */
// infrared frame transmitter: one item in, one result item out, registered
// a result goes to the output register, or to the skid entry while the output stalls
// throughput: one item per cycle while the skid entry is empty, set by one pass through the
// phase and tick counters; the two-entry output buffer accepts input while the output stalls
// reset: asynchronous, active low; block idle, all but the result data at default values
`include "assert_macros.svh"

module ir_remote_frame_transmitter_core
  import irft_pkg::*;
#(
  parameter int unsigned CODE_BITS = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                mode_i,
  input  logic [CmdW-1:0]     command_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                carrier_on_o,
  output logic                led_on_o,
  output logic                busy_res_o,
  output logic                done_res_o
);

  localparam int unsigned BitW = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;
  localparam logic [BitW-1:0] BitLast = BitW'(CODE_BITS - 1);
  localparam int unsigned RawW = AddrW + CmdW;

  // configuration
  logic [AddrW-1:0]  dev_addr_q;
  logic [FrameW-1:0] frame_cnt_q;
  logic [TickW-1:0]  gap_q;
  logic [MarkW-1:0]  start_mark_q, one_mark_q, zero_mark_q, space_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q   <= RstDeviceAddress;
      frame_cnt_q  <= RstFrameCount;
      gap_q        <= RstFrameGap;
      start_mark_q <= RstStartMark;
      one_mark_q   <= RstOneMark;
      zero_mark_q  <= RstZeroMark;
      space_q      <= RstSpace;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEVICE_ADDRESS:   dev_addr_q   <= cfg_wdata_i[AddrW-1:0];
        CFG_FRAME_COUNT:      frame_cnt_q  <= cfg_wdata_i[FrameW-1:0];
        CFG_FRAME_GAP_TICKS:  gap_q        <= cfg_wdata_i[TickW-1:0];
        CFG_START_MARK_TICKS: start_mark_q <= cfg_wdata_i[MarkW-1:0];
        CFG_ONE_MARK_TICKS:   one_mark_q   <= cfg_wdata_i[MarkW-1:0];
        CFG_ZERO_MARK_TICKS:  zero_mark_q  <= cfg_wdata_i[MarkW-1:0];
        CFG_SPACE_TICKS:      space_q      <= cfg_wdata_i[MarkW-1:0];
        default: ;
      endcase
    end
  end

  // transmit state
  phase_e              phase_q, phase_d;
  logic [TickW-1:0]    tick_q, tick_d;
  logic [BitW-1:0]     bit_q, bit_d;
  logic [FrameW-1:0]   frames_q, frames_d;
  logic [CODE_BITS-1:0] code_q, code_d;

  logic in_acc;
  logic is_send, is_tick;
  logic [TickW-1:0] seg_raw, seg_len, tick_inc;
  logic seg_end, last_bit, last_frame;
  logic [RawW+CODE_BITS-1:0] code_ext;
  result_t res;

  assign in_acc  = in_valid_i && in_ready_o;
  assign is_send = (mode_i == MODE_SEND);
  assign is_tick = (mode_i == MODE_TICK) && (phase_q != PH_IDLE);

  // segment length of the current phase, a zero length lasts one tick
  always_comb begin
    case (phase_q)
      PH_START_MARK: seg_raw = TickW'(start_mark_q);
      PH_BIT_MARK:   seg_raw = code_q[0] ? TickW'(one_mark_q) : TickW'(zero_mark_q);
      PH_GAP:        seg_raw = gap_q;
      default:       seg_raw = TickW'(space_q);
    endcase
    seg_len = (seg_raw == '0) ? TickW'(1) : seg_raw;
  end

  assign tick_inc   = tick_q + TickW'(1);
  assign seg_end    = (tick_inc >= seg_len);
  assign last_bit   = (bit_q == BitLast);
  assign last_frame = (frames_q == FrameW'(1));
  assign code_ext   = {{CODE_BITS{1'b0}}, dev_addr_q, command_i};

  // next state
  always_comb begin
    phase_d  = phase_q;
    tick_d   = tick_q;
    bit_d    = bit_q;
    frames_d = frames_q;
    code_d   = code_q;
    if (is_send) begin
      if (phase_q == PH_IDLE) begin
        code_d   = code_ext[CODE_BITS-1:0];
        frames_d = (frame_cnt_q == '0) ? FrameW'(1) : frame_cnt_q;
        phase_d  = PH_START_MARK;
        tick_d   = '0;
        bit_d    = '0;
      end
    end else if (is_tick) begin
      tick_d = tick_inc;
      if (seg_end) begin
        tick_d = '0;
        case (phase_q)
          PH_START_MARK:  phase_d = PH_START_SPACE;
          PH_START_SPACE: begin
            bit_d   = '0;
            phase_d = PH_BIT_MARK;
          end
          PH_BIT_MARK:    phase_d = PH_BIT_SPACE;
          PH_BIT_SPACE: begin
            // rotating keeps the word intact for the next frame
            code_d = {code_q[0], code_q[CODE_BITS-1:1]};
            if (!last_bit) begin
              bit_d   = bit_q + BitW'(1);
              phase_d = PH_BIT_MARK;
            end else begin
              bit_d    = '0;
              frames_d = frames_q - FrameW'(1);
              if (last_frame) begin
                phase_d = PH_IDLE;
              end else if (gap_q != '0) begin
                phase_d = PH_GAP;
              end else begin
                phase_d = PH_START_MARK;
              end
            end
          end
          default:        phase_d = PH_START_MARK;
        endcase
      end
    end
  end

  // result of the item
  always_comb begin
    res.busy       = is_send || is_tick;
    res.carrier_on = is_tick && (phase_q == PH_START_MARK || phase_q == PH_BIT_MARK);
    res.done       = is_tick && seg_end && (phase_q == PH_BIT_SPACE) && last_bit && last_frame;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      tick_q   <= '0;
      bit_q    <= '0;
      frames_q <= '0;
      code_q   <= '0;
    end else if (in_acc) begin
      phase_q  <= phase_d;
      tick_q   <= tick_d;
      bit_q    <= bit_d;
      frames_q <= frames_d;
      code_q   <= code_d;
    end
  end

  // output register plus skid entry
  logic    out_vld_q, skid_vld_q;
  result_t out_q, skid_q;
  logic    out_pop;

  assign in_ready_o = !skid_vld_q;
  assign out_pop    = out_vld_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_pop) begin
        skid_vld_q <= 1'b0;
      end
    end else if (!out_vld_q || out_pop) begin
      out_vld_q <= in_acc;
    end else if (in_acc) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_pop) begin
        out_q <= skid_q;
      end
    end else if (!out_vld_q || out_pop) begin
      out_q <= res;
    end else if (in_acc) begin
      skid_q <= res;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign carrier_on_o = out_q.carrier_on;
  assign led_on_o     = out_q.busy;
  assign busy_res_o   = out_q.busy;
  assign done_res_o   = out_q.done;

  `ASSERT_IMPLY(a_skid_behind_out, clk_i, rst_ni, skid_vld_q, out_vld_q)
  `ASSERT_IMPLY(a_busy_has_frames, clk_i, rst_ni, phase_q != PH_IDLE, frames_q != '0)
  `ASSERT_IMPLY(a_bit_in_range, clk_i, rst_ni, 1'b1, bit_q <= BitLast)
  `ASSERT_NEXT(a_done_goes_idle, clk_i, rst_ni, in_acc && res.done, phase_q == PH_IDLE)
  `ASSERT_NEXT(a_send_starts, clk_i, rst_ni, in_acc && is_send && phase_q == PH_IDLE,
               phase_q == PH_START_MARK && tick_q == '0)

endmodule
